// ===== rtl/roa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package roa_pkg;
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [11:0] THRESH_RESET = 12'd2;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [6:0] ROUND_ADD = 7'd40;
  localparam logic [6:0] SCALE = 7'd100;
endpackage
`default_nettype wire

// ===== rtl/runqueue_occupancy_averager_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Run-queue occupancy averager.
// Input channel (in_valid_i / in_stall_o) carries one beat per event:
//   op 0 update, op 1 poll all CPUs, op 2 query one CPU's high load.
// Output channel (out_valid_o / out_stall_i) carries one beat per CPU for a
//   poll (last on the final CPU) and one beat for a query.
// One shared 32x12 multiplier (64x12 products in two halves) and one
//   restoring divider (for the divisions by the poll period) do the
//   arithmetic; the rounding by 100 runs on a radix-256 step, byte by byte.
// An update holds in_stall_o high through two products and the write.
// A poll handles the CPUs one after another; for each CPU three divisions
//   by the poll period take most of the time.
// A query runs three products and one division. Ignored beats leave it idle.
// A finished result sits in the output register; while the receiver stalls
//   the sequencer holds in front of it and the result stays put.
// Reset clears all per-CPU sums, counts and timestamps and sets the
//   threshold to 2. State lives in flip-flops, so no clearing pass is needed.
module runqueue_occupancy_averager_unit
  import roa_pkg::*;
#(
  parameter int CPU_COUNT = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [11:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  op_i,
  input  wire  [2:0]  cpu_index_i,
  input  wire  [63:0] now_i,
  input  wire  [11:0] new_count_i,
  input  wire  [11:0] big_count_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  cpu_index_out_o,
  output logic [31:0] avg_running_o,
  output logic [31:0] avg_misfit_o,
  output logic [11:0] max_running_o,
  output logic [31:0] scaled_running_o,
  output logic [31:0] scaled_high_o,
  output logic        last_o
);
  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;  // run a product
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;  // run a division
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_NEXT = 4'd5;
  localparam logic [3:0] S_DC   = 4'd6;  // divide by 100, one byte per cycle

  // floor(v / 100) = (v * 5243) >> 19 for v below 25600
  localparam logic [12:0] RECIP100 = 13'd5243;
  // 100 * 2^32: at or above this the rounded average saturates
  localparam logic [63:0] RND_SAT = 64'd429496729600;

  logic [11:0] thresh_q;
  logic [63:0] let_q [CPU_COUNT];
  logic [11:0] cur_q [CPU_COUNT];
  logic [11:0] peak_q [CPU_COUNT];
  logic [63:0] cts_q [CPU_COUNT];
  logic [63:0] bts_q [CPU_COUNT];
  logic [63:0] hts_q [CPU_COUNT];
  logic [11:0] lbc_q [CPU_COUNT];
  logic [63:0] lpt_q;

  logic [3:0]  st_q;
  logic [3:0]  step_q;     // micro-step within an item
  logic [1:0]  op_q;
  logic [CW-1:0] c_q;
  logic [63:0] now_q, diff_q, period_q;
  logic [11:0] newc_q, bigc_q;
  logic [63:0] nr_q, mis_q, hi_q;   // sums with open interval, then scaled

  // shared multiplier: 32 x 12, one half per cycle
  logic [63:0] ma_q, macc_q;
  logic [11:0] mb_q;
  logic        mhalf_q;
  logic [43:0] mprod;
  assign mprod = {12'd0, mhalf_q ? ma_q[63:32] : ma_q[31:0]} * {32'd0, mb_q};

  // shared restoring divider, 64/64, one bit per cycle
  logic [63:0] dn_q, dd_q, dq_q, dr_q;
  logic [6:0]  dcnt_q;
  logic [64:0] dtrial;
  assign dtrial = {dr_q, dn_q[63]} - {1'b0, dd_q};

  // divide by 100: remainder times 256 plus the next byte, per cycle
  logic [39:0] kn_q;
  logic [31:0] kq_q;
  logic [6:0]  krem_q;
  logic [2:0]  kcnt_q;
  logic        ksat_q;
  logic [14:0] kv;
  logic [27:0] kmul;
  logic [7:0]  kqd;
  logic [14:0] krem;
  logic [31:0] kres;
  assign kv = {krem_q, kn_q[39:32]};
  assign kmul = {13'd0, kv} * {15'd0, RECIP100};
  assign kqd = 8'(kmul >> 19);
  assign krem = kv - {7'd0, kqd} * {8'd0, SCALE};
  assign kres = ksat_q ? SAT32 : kq_q;

  logic [3:0] ret_q;  // step to resume at after mul/div

  logic outv_q;
  logic [2:0] oidx_q;
  logic [31:0] oavg_q, omis_q, oscr_q, oshi_q;
  logic [11:0] omax_q;
  logic olast_q;

  logic accept;
  assign in_stall_o = (st_q != S_IDLE);
  assign accept = in_valid_i && (st_q == S_IDLE);

  // load the output register when it is empty or its beat leaves now
  logic out_load;
  assign out_load = (st_q == S_OUT) && (!outv_q || !out_stall_i);

  function automatic logic [31:0] sat(input logic [63:0] v);
    sat = (v > {32'd0, SAT32}) ? SAT32 : v[31:0];
  endfunction

  logic [CW-1:0] cin;
  assign cin = CW'(cpu_index_i);
  logic cpu_ok;
  assign cpu_ok = ({29'd0, cpu_index_i} < CPU_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      lpt_q <= '0;
      for (int i = 0; i < CPU_COUNT; i++) begin
        let_q[i] <= '0; cur_q[i] <= '0; peak_q[i] <= '0; cts_q[i] <= '0;
        bts_q[i] <= '0; hts_q[i] <= '0; lbc_q[i] <= '0;
      end
      st_q <= S_IDLE;
      outv_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (cfg_we_i) thresh_q <= cfg_wdata_i;
      if (out_load) outv_q <= 1'b1;
      else if (outv_q && !out_stall_i) outv_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= op_i; c_q <= (op_i == OP_POLL) ? '0 : cin; now_q <= now_i;
            newc_q <= new_count_i; bigc_q <= big_count_i;
            period_q <= now_i - lpt_q;
            if (op_i == OP_UPDATE && cpu_ok) begin
              diff_q <= now_i - let_q[cin];
              step_q <= 4'd0; st_q <= S_UPD;
            end else if (op_i == OP_QUERY && cpu_ok) begin
              diff_q <= now_i - let_q[cin];
              step_q <= 4'd0; st_q <= S_NEXT;
            end else if (op_i == OP_POLL && now_i != lpt_q) begin
              diff_q <= now_i - let_q[0];
              step_q <= 4'd0; st_q <= S_NEXT;
            end
          end
        end
        S_MUL: begin
          // accumulate one 32-bit half of ma * mb
          if (!mhalf_q) macc_q <= {20'd0, mprod};
          else macc_q <= macc_q + {mprod[31:0], 32'd0};
          mhalf_q <= 1'b1;
          if (mhalf_q) begin st_q <= (op_q == OP_UPDATE) ? S_UPD : S_NEXT; step_q <= ret_q; end
        end
        S_DIV: begin
          if (!dtrial[64]) begin
            dr_q <= dtrial[63:0]; dq_q <= {dq_q[62:0], 1'b1};
          end else begin
            dr_q <= {dr_q[62:0], dn_q[63]}; dq_q <= {dq_q[62:0], 1'b0};
          end
          dn_q <= {dn_q[62:0], 1'b0};
          dcnt_q <= dcnt_q - 7'd1;
          if (dcnt_q == 7'd1) begin st_q <= S_NEXT; step_q <= ret_q; end
        end
        S_DC: begin
          // advance one quotient byte
          kq_q <= {kq_q[23:0], kqd};
          krem_q <= 7'(krem);
          kn_q <= {kn_q[31:0], 8'd0};
          kcnt_q <= kcnt_q - 3'd1;
          if (kcnt_q == 3'd1) begin st_q <= S_NEXT; step_q <= ret_q; end
        end
        S_UPD: begin
          unique case (step_q)
            4'd0: begin
              ma_q <= diff_q; mb_q <= cur_q[c_q]; mhalf_q <= 1'b0;
              ret_q <= 4'd1; st_q <= S_MUL;
            end
            4'd1: begin
              nr_q <= macc_q;
              ma_q <= diff_q; mb_q <= bigc_q; mhalf_q <= 1'b0;
              ret_q <= 4'd2; st_q <= S_MUL;
            end
            default: begin
              cts_q[c_q] <= cts_q[c_q] + nr_q;
              if (cur_q[c_q] >= thresh_q) hts_q[c_q] <= hts_q[c_q] + nr_q;
              bts_q[c_q] <= bts_q[c_q] + macc_q;
              let_q[c_q] <= now_q; cur_q[c_q] <= newc_q;
              if (newc_q > peak_q[c_q]) peak_q[c_q] <= newc_q;
              lbc_q[c_q] <= bigc_q;
              st_q <= S_IDLE;
            end
          endcase
        end
        S_NEXT: begin
          // sequencer for poll and query
          case (step_q)
            4'd0: begin
              ma_q <= diff_q; mb_q <= cur_q[c_q]; mhalf_q <= 1'b0;
              ret_q <= 4'd1; st_q <= S_MUL;
            end
            4'd1: begin
              nr_q <= cts_q[c_q] + macc_q;
              hi_q <= hts_q[c_q] + ((cur_q[c_q] >= thresh_q) ? macc_q : 64'd0);
              ma_q <= diff_q; mb_q <= lbc_q[c_q]; mhalf_q <= 1'b0;
              ret_q <= 4'd2; st_q <= S_MUL;
            end
            4'd2: begin
              mis_q <= bts_q[c_q] + macc_q;
              ma_q <= hi_q; mb_q <= {5'd0, SCALE}; mhalf_q <= 1'b0;
              ret_q <= 4'd3; st_q <= S_MUL;
            end
            4'd3: begin
              // hi*100 / period
              dn_q <= macc_q; dd_q <= period_q; dr_q <= '0; dcnt_q <= 7'd64;
              ret_q <= (op_q == OP_QUERY) ? 4'd12 : 4'd4; st_q <= S_DIV;
            end
            4'd4: begin
              hi_q <= dq_q;
              ma_q <= nr_q; mb_q <= {5'd0, SCALE}; mhalf_q <= 1'b0;
              ret_q <= 4'd5; st_q <= S_MUL;
            end
            4'd5: begin
              dn_q <= macc_q; dd_q <= period_q; dr_q <= '0; dcnt_q <= 7'd64;
              ret_q <= 4'd6; st_q <= S_DIV;
            end
            4'd6: begin
              nr_q <= dq_q;
              ma_q <= mis_q; mb_q <= {5'd0, SCALE}; mhalf_q <= 1'b0;
              ret_q <= 4'd7; st_q <= S_MUL;
            end
            4'd7: begin
              dn_q <= macc_q; dd_q <= period_q; dr_q <= '0; dcnt_q <= 7'd64;
              ret_q <= 4'd8; st_q <= S_DIV;
            end
            4'd8: begin
              // round the runnable average
              mis_q <= dq_q;
              kn_q <= 40'(nr_q + {57'd0, ROUND_ADD});
              ksat_q <= ((nr_q + {57'd0, ROUND_ADD}) >= RND_SAT);
              kq_q <= '0; krem_q <= '0; kcnt_q <= 3'd5;
              ret_q <= 4'd9; st_q <= S_DC;
            end
            4'd9: begin
              oavg_q <= kres;
              kn_q <= 40'(mis_q + {57'd0, ROUND_ADD});
              ksat_q <= ((mis_q + {57'd0, ROUND_ADD}) >= RND_SAT);
              kq_q <= '0; krem_q <= '0; kcnt_q <= 3'd5;
              ret_q <= 4'd10; st_q <= S_DC;
            end
            4'd10: begin
              omis_q <= kres;
              omax_q <= peak_q[c_q]; oscr_q <= sat(nr_q); oshi_q <= sat(hi_q);
              oidx_q <= 3'({{(8-CW){1'b0}}, c_q});
              olast_q <= ({{(32-CW){1'b0}}, c_q} == 32'(CPU_COUNT - 1));
              step_q <= 4'd11; st_q <= S_OUT;
            end
            4'd12: begin
              oavg_q <= '0; omis_q <= '0; omax_q <= '0; oscr_q <= '0;
              oshi_q <= (period_q == 64'd0) ? SAT32 : sat(dq_q);
              oidx_q <= 3'({{(8-CW){1'b0}}, c_q}); olast_q <= 1'b1;
              step_q <= 4'd13; st_q <= S_OUT;
            end
            default: st_q <= S_IDLE;
          endcase
        end
        S_OUT: begin
          // wait for the output register to drain, then load the beat
          if (out_load) begin
            cpu_index_out_o <= oidx_q; avg_running_o <= oavg_q;
            avg_misfit_o <= omis_q; max_running_o <= omax_q;
            scaled_running_o <= oscr_q; scaled_high_o <= oshi_q; last_o <= olast_q;
            if (step_q == 4'd13) st_q <= S_IDLE;
            else begin
              let_q[c_q] <= now_q; cts_q[c_q] <= '0; bts_q[c_q] <= '0;
              hts_q[c_q] <= '0; peak_q[c_q] <= cur_q[c_q];
              if (olast_q) begin
                lpt_q <= now_q; st_q <= S_IDLE;
              end else begin
                c_q <= c_q + 1'b1;
                diff_q <= now_q - let_q[c_q + 1'b1];
                step_q <= 4'd0; st_q <= S_NEXT;
              end
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = outv_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> in_stall_o) else $error("accepting while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(scaled_high_o)))
    else $error("stalled result changed");
  a_div_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV && dcnt_q == 7'd1) |=> (st_q == S_NEXT))
    else $error("divider did not return");
endmodule
`default_nettype wire
